### hdl/cfp_pkg.sv
// shared types and constants of the checksummed command frame parser
package cfp_pkg;

    localparam int BYTE_W   = 8;
    localparam int DRIVE_W  = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CMD_SLOTS = 5;

    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_TARGET_A    = 3'd1,
        ACT_TARGET_B    = 3'd2,
        ACT_SECOND_DOWN = 3'd3,
        ACT_FIRST_DOWN  = 3'd4,
        ACT_FIRST_UP    = 3'd5
    } action_t;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_CHECK   = 4'b0100,
        PH_TRAIL   = 4'b1000
    } phase_t;

    localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 3'd5;

    typedef struct packed {
        logic    push;
        action_t act;
    } cmd_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

### hdl/checksummed_command_frame_parser.sv
// top level of the checksummed command frame parser
// a command enters the command queue when its trailer is accepted, then the output register
// throughput: one byte per cycle, set by the front parser
// the two-entry command queue stalls input bytes only while full
// reset: synchronous active-low aresetn clears parser, queue, drives and registers to defaults
module checksummed_command_frame_parser import cfp_pkg::*; #(
    parameter int PAYLOAD_BYTES = 5
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [BYTE_W-1:0]         cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [BYTE_W-1:0]         s_rx_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_action,
    output logic [BYTE_W-1:0]         m_target_x,
    output logic [BYTE_W-1:0]         m_target_y,
    output logic signed [DRIVE_W-1:0] m_drive_first,
    output logic signed [DRIVE_W-1:0] m_drive_second
);

    logic [BYTE_W-1:0] header_reg, trailer_reg, step_reg;
    logic [BYTE_W-1:0] tax_reg, tbx_reg, ty_reg;
    cmd_req_t          cmd_req;
    queue_stat_t       stat;
    action_t           head;
    logic              pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= 8'hA5;
            trailer_reg <= 8'h5A;
            step_reg    <= 8'd10;
            tax_reg     <= 8'd80;
            tbx_reg     <= 8'd20;
            ty_reg      <= 8'd60;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_HEADER:   header_reg  <= cfg_data;
                REG_TRAILER:  trailer_reg <= cfg_data;
                REG_STEP:     step_reg    <= cfg_data;
                REG_TARGET_A: tax_reg     <= cfg_data;
                REG_TARGET_B: tbx_reg     <= cfg_data;
                REG_TARGET_Y: ty_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !stat.full;

    cfp_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_en      (s_valid && s_ready),
        .rx_byte      (s_rx_byte),
        .header_byte  (header_reg),
        .trailer_byte (trailer_reg),
        .cmd_req      (cmd_req)
    );

    cfp_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd_req (cmd_req),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    cfp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .stat           (stat),
        .pop            (pop),
        .drive_step     (step_reg),
        .target_a_x     (tax_reg),
        .target_b_x     (tbx_reg),
        .target_y_value (ty_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_target_x     (m_target_x),
        .m_target_y     (m_target_y),
        .m_drive_first  (m_drive_first),
        .m_drive_second (m_drive_second)
    );

endmodule

### hdl/cfp_front.sv
// frame hunting, checksum check and command selection
module cfp_front import cfp_pkg::*; #(
    parameter int PAYLOAD_BYTES = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_en,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic [BYTE_W-1:0] header_byte,
    input  logic [BYTE_W-1:0] trailer_byte,
    output cmd_req_t          cmd_req
);

    localparam int CNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_BYTES - 1);

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    action_t           cmd_reg, cmd_next;
    logic              slot_hit;

    assign slot_hit = (32'(cnt_reg) < CMD_SLOTS) && (rx_byte == BYTE_W'(1))
                      && (cmd_reg == ACT_NONE);

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        sum_next     = sum_reg;
        cmd_next     = cmd_reg;
        cmd_req.push = 1'b0;
        cmd_req.act  = cmd_reg;
        if (byte_en) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (rx_byte == header_byte) begin
                        phase_next = PH_PAYLOAD;
                        cnt_next   = '0;
                        sum_next   = '0;
                        cmd_next   = ACT_NONE;
                    end
                end
                PH_PAYLOAD: begin
                    sum_next = sum_reg + rx_byte;
                    if (slot_hit) begin
                        cmd_next = action_t'(3'(cnt_reg) + 3'd1);
                    end
                    if (cnt_reg == CNT_LAST) begin
                        phase_next = PH_CHECK;
                    end else begin
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                PH_CHECK: begin
                    sum_next   = sum_reg ^ rx_byte;
                    phase_next = PH_TRAIL;
                end
                PH_TRAIL: begin
                    phase_next   = PH_HUNT;
                    cnt_next     = '0;
                    cmd_req.push = (sum_reg == '0) && (rx_byte == trailer_byte);
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            cmd_reg   <= ACT_NONE;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            cmd_reg   <= cmd_next;
        end
    end

endmodule

### hdl/cfp_queue.sv
// two-entry command queue between front and back
module cfp_queue import cfp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_req_t    cmd_req,
    input  logic        pop,
    output action_t     head,
    output queue_stat_t stat
);

    action_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push, do_pop;

    assign stat.full  = (fill_reg == 2'd2);
    assign stat.empty = (fill_reg == 2'd0);
    assign do_push    = cmd_req.push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= cmd_req.act;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

### hdl/cfp_back.sv
// command execution, drive values and result register
module cfp_back import cfp_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  action_t                   head,
    input  queue_stat_t               stat,
    output logic                      pop,
    input  logic [BYTE_W-1:0]         drive_step,
    input  logic [BYTE_W-1:0]         target_a_x,
    input  logic [BYTE_W-1:0]         target_b_x,
    input  logic [BYTE_W-1:0]         target_y_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_action,
    output logic [BYTE_W-1:0]         m_target_x,
    output logic [BYTE_W-1:0]         m_target_y,
    output logic signed [DRIVE_W-1:0] m_drive_first,
    output logic signed [DRIVE_W-1:0] m_drive_second
);

    logic                      valid_reg, valid_next;
    action_t                   act_reg;
    logic [BYTE_W-1:0]         tx_reg, tx_next;
    logic [BYTE_W-1:0]         ty_reg, ty_next;
    logic signed [DRIVE_W-1:0] first_reg, first_next;
    logic signed [DRIVE_W-1:0] second_reg, second_next;
    logic signed [DRIVE_W:0]   first_up, first_dn, second_dn;

    function automatic logic signed [DRIVE_W-1:0] sat(input logic signed [DRIVE_W:0] v);
        logic signed [DRIVE_W-1:0] r;
        if (v[DRIVE_W] != v[DRIVE_W-1]) begin
            r = v[DRIVE_W] ? {1'b1, {(DRIVE_W-1){1'b0}}} : {1'b0, {(DRIVE_W-1){1'b1}}};
        end else begin
            r = v[DRIVE_W-1:0];
        end
        return r;
    endfunction

    assign pop = !stat.empty && (!valid_reg || m_ready);

    assign first_up  = {first_reg[DRIVE_W-1], first_reg} + $signed({9'd0, drive_step});
    assign first_dn  = {first_reg[DRIVE_W-1], first_reg} - $signed({9'd0, drive_step});
    assign second_dn = {second_reg[DRIVE_W-1], second_reg} - $signed({9'd0, drive_step});

    always_comb begin
        valid_next  = valid_reg && !m_ready;
        tx_next     = '0;
        ty_next     = '0;
        first_next  = first_reg;
        second_next = second_reg;
        if (pop) begin
            valid_next = 1'b1;
            case (head)
                ACT_TARGET_A: begin
                    tx_next = target_a_x;
                    ty_next = target_y_value;
                end
                ACT_TARGET_B: begin
                    tx_next = target_b_x;
                    ty_next = target_y_value;
                end
                ACT_SECOND_DOWN: second_next = sat(second_dn);
                ACT_FIRST_DOWN:  first_next  = sat(first_dn);
                ACT_FIRST_UP:    first_next  = sat(first_up);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            act_reg <= head;
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
        end else begin
            valid_reg  <= valid_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_action       = act_reg;
    assign m_target_x     = tx_reg;
    assign m_target_y     = ty_reg;
    assign m_drive_first  = first_reg;
    assign m_drive_second = second_reg;

endmodule

### hdl/cfp_checker.sv
// port-level assertions for the checksummed command frame parser
module cfp_checker import cfp_pkg::*; (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [2:0]                m_action,
    input logic [BYTE_W-1:0]         m_target_x,
    input logic [BYTE_W-1:0]         m_target_y
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_action))
        else $error("stalled result dropped or changed");

    a_action_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_action <= ACT_FIRST_UP))
        else $error("action code out of range");

    a_targets_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_action != ACT_TARGET_A && m_action != ACT_TARGET_B
            |-> m_target_x == '0 && m_target_y == '0)
        else $error("targets set for a non-target action");

endmodule

bind checksummed_command_frame_parser cfp_checker u_cfp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_action   (m_action),
    .m_target_x (m_target_x),
    .m_target_y (m_target_y)
);
